FILE: rtl/ilst_pkg.sv
// Package for the indexed LCG sequence table: generator constants, FSM state
// type, result mode codes and the scaling request bundle.
// No dependencies; all rtl/ files but ilst_word_mem use it by scoped names.
package ilst_pkg;

    // Generator: s(n+1) = s(n) * LCG_MUL + LCG_INC, modulo 2^64.
    localparam logic [63:0] LCG_MUL = 64'h5d58_8b65_6c07_8965;
    localparam logic [63:0] LCG_INC = 64'h0000_0000_0026_9ec3;
    localparam logic [31:0] LCG_MUL_LO = LCG_MUL[31:0];
    localparam logic [31:0] LCG_MUL_HI = LCG_MUL[63:32];

    // Result modes.
    typedef enum logic [1:0] {
        MODE_SCALED    = 2'd0,
        MODE_RANGE_INT = 2'd1,
        MODE_RANGE_FIX = 2'd2,
        MODE_RAW       = 2'd3
    } mode_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_GEN_MUL,
        ST_GEN_ADD,
        ST_READ,
        ST_FINISH
    } state_t;

    // Request held stable for the scaling unit while an item is in work.
    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] bound_low;
        logic signed [31:0] bound_high;
    } scale_req_t;

endpackage

FILE: rtl/indexed_lcg_sequence_table.sv
// Indexed LCG sequence table, top level.
// Flow: an accepted item passes FILL, READ and FINISH into the output register
// (out-of-range positions go straight to FINISH); FINISH holds while the output
// stalls. A read that must generate words first loops GEN_MUL and GEN_ADD once
// per new word, then FILL rechecks the fill count. A new item is taken only in IDLE.
// Reset: the seed clears to 0 and the fill count to 1; the table is not cleared.
module indexed_lcg_sequence_table #(
    parameter int TABLE_DEPTH = 8192
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_write_en,
    input  logic [63:0]        start_seed,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [12:0]        position,
    input  logic signed [31:0] bound_low,
    input  logic signed [31:0] bound_high,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [32:0] value,
    output logic [13:0]        next_position,
    output logic               out_of_range
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // Sequencer state and the generator's architectural state.
    ilst_pkg::state_t     state_reg;
    ilst_pkg::state_t     state_next;
    logic [63:0]          seed_reg;
    logic [CNT_W-1:0]     fill_cnt_reg;

    // The accepted item, held for the whole of its work.
    ilst_pkg::scale_req_t req_reg;
    logic [12:0]          pos_reg;
    logic                 oor_reg;

    // Output register; it parts the result from the input side.
    logic                 out_valid_reg;
    logic signed [32:0]   value_reg;
    logic [13:0]          next_pos_reg;
    logic                 out_oor_reg;

    logic                 in_xfer;
    logic                 out_xfer;
    logic                 out_free;
    logic                 pos_oor;
    logic                 need_gen;
    logic                 more_gen;
    logic                 gen_write;
    logic                 rd_en;
    logic                 load_out;

    logic [63:0]          next_seed;
    logic [31:0]          rd_data;
    logic [31:0]          word;
    logic signed [32:0]   scaled_value;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Positions compare against the depth and the fill count at 32 bits, so
    // any legal depth works with the fixed 13-bit position field.
    assign pos_oor  = 32'(position) >= 32'(TABLE_DEPTH);
    assign need_gen = 32'(fill_cnt_reg) <= 32'(pos_reg);
    assign more_gen = 32'(fill_cnt_reg) < 32'(pos_reg);

    // Next-state logic. Words are produced in order until the fill count
    // passes the requested position; the read is then issued from FILL so it
    // never meets the write to the same entry.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ilst_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = pos_oor ? ilst_pkg::ST_FINISH : ilst_pkg::ST_FILL;
                end
            end
            ilst_pkg::ST_FILL:
            begin
                state_next = need_gen ? ilst_pkg::ST_GEN_MUL : ilst_pkg::ST_READ;
            end
            ilst_pkg::ST_GEN_MUL:
            begin
                state_next = ilst_pkg::ST_GEN_ADD;
            end
            ilst_pkg::ST_GEN_ADD:
            begin
                state_next = more_gen ? ilst_pkg::ST_GEN_MUL : ilst_pkg::ST_FILL;
            end
            ilst_pkg::ST_READ:
            begin
                state_next = ilst_pkg::ST_FINISH;
            end
            ilst_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ilst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ilst_pkg::ST_IDLE;
            end
        endcase
    end

    // Output decode of the sequencer.
    always_comb
    begin
        in_stall  = 1'b1;
        gen_write = 1'b0;
        rd_en     = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ilst_pkg::ST_IDLE:    in_stall  = 1'b0;
            ilst_pkg::ST_FILL:    rd_en     = !need_gen;
            ilst_pkg::ST_GEN_MUL: gen_write = 1'b0;
            ilst_pkg::ST_GEN_ADD: gen_write = 1'b1;
            ilst_pkg::ST_READ:    rd_en     = 1'b0;
            ilst_pkg::ST_FINISH:  load_out  = out_free;
            default:              in_stall  = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ilst_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Seed write restarts the sequence; user must issue it only while idle, unenforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg     <= 64'd0;
            fill_cnt_reg <= CNT_W'(1);
        end
        else if (cfg_write_en)
        begin
            seed_reg     <= start_seed;
            fill_cnt_reg <= CNT_W'(1);
        end
        else if (gen_write)
        begin
            seed_reg     <= next_seed;
            fill_cnt_reg <= fill_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg.mode       <= ilst_pkg::mode_t'(mode);
            req_reg.bound_low  <= bound_low;
            req_reg.bound_high <= bound_high;
            pos_reg            <= position;
            oor_reg            <= pos_oor;
        end
    end

    ilst_lcg_step u_lcg (
        .clk       (clk),
        .seed      (seed_reg),
        .next_seed (next_seed)
    );

    ilst_word_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (gen_write),
        .wr_addr (fill_cnt_reg[ADDR_W-1:0]),
        .wr_data (next_seed[63:32]),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(pos_reg)),
        .rd_data (rd_data)
    );

    // Slot 0 is never generated and always reads as zero.
    assign word = (pos_reg == 13'd0) ? 32'd0 : rd_data;

    ilst_scale u_scale (
        .clk   (clk),
        .req   (req_reg),
        .word  (word),
        .value (scaled_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // An out-of-range position returns zero and echoes the position.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            value_reg    <= oor_reg ? 33'sd0 : scaled_value;
            next_pos_reg <= oor_reg ? 14'(pos_reg) : 14'(pos_reg) + 14'd1;
            out_oor_reg  <= oor_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign value         = value_reg;
    assign next_position = next_pos_reg;
    assign out_of_range  = out_oor_reg;

endmodule

FILE: rtl/ilst_word_mem.sv
// Word cache memory: one write port and one read port, registered read data.
// Depends on nothing but its parameters.
module ilst_word_mem #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/ilst_lcg_step.sv
// One step of the 64-bit LCG, split into three 32x32 partial products that
// are registered, then summed. Depends on ilst_pkg for the multiplier.
module ilst_lcg_step (
    input  logic        clk,
    input  logic [63:0] seed,
    output logic [63:0] next_seed
);

    logic [63:0] p_lo_lo;
    logic [63:0] p_hi_lo;
    logic [63:0] p_lo_hi;
    logic [63:0] p_lo_lo_reg;
    logic [31:0] p_hi_lo_reg;
    logic [31:0] p_lo_hi_reg;
    logic [31:0] cross_sum;

    // Only the low half of the cross products survives the modulo 2^64.
    assign p_lo_lo = 64'(seed[31:0]) * 64'(ilst_pkg::LCG_MUL_LO);
    assign p_hi_lo = 64'(seed[63:32]) * 64'(ilst_pkg::LCG_MUL_LO);
    assign p_lo_hi = 64'(seed[31:0]) * 64'(ilst_pkg::LCG_MUL_HI);

    always_ff @(posedge clk)
    begin
        p_lo_lo_reg <= p_lo_lo;
        p_hi_lo_reg <= p_hi_lo[31:0];
        p_lo_hi_reg <= p_lo_hi[31:0];
    end

    assign cross_sum = p_hi_lo_reg + p_lo_hi_reg;
    assign next_seed = p_lo_lo_reg + {cross_sum, 32'd0} + ilst_pkg::LCG_INC;

endmodule

FILE: rtl/ilst_scale.sv
// Scaling unit: treats the cached word as a 0.32 fraction and maps it onto
// the requested span with a floor; raw mode passes it on. Registered
// product, then sum and clamp. Needs ilst_pkg mode codes, request struct.
module ilst_scale (
    input  logic                   clk,
    input  ilst_pkg::scale_req_t   req,
    input  logic [31:0]            word,
    output logic signed [32:0]     value
);

    localparam logic signed [34:0] VAL_MAX = 35'sd4294967295;
    localparam logic signed [34:0] VAL_MIN = -35'sd4294967296;

    logic signed [33:0] lo_ext;
    logic signed [33:0] hi_ext;
    logic signed [33:0] span;
    logic               neg;
    logic [32:0]        mag;
    logic [64:0]        prod;

    logic [64:0]        prod_reg;
    logic               neg_reg;
    logic [31:0]        word_reg;
    ilst_pkg::mode_t    mode_reg;
    logic signed [31:0] lo_reg;

    logic [64:0]        rounded;
    logic [32:0]        quot;
    logic signed [34:0] scaled;
    logic signed [34:0] base;
    logic signed [34:0] sum;

    // Span selection and magnitude for the multiply.
    always_comb
    begin
        lo_ext = 34'(req.bound_low);
        hi_ext = 34'(req.bound_high);
        unique case (req.mode)
            ilst_pkg::MODE_SCALED:    span = hi_ext;
            ilst_pkg::MODE_RANGE_INT: span = hi_ext - lo_ext + 34'sd1;
            ilst_pkg::MODE_RANGE_FIX: span = hi_ext - lo_ext;
            default:                  span = hi_ext;
        endcase
        neg  = span[33];
        mag  = neg ? 33'(-span) : 33'(span);
        prod = 65'(word) * 65'(mag);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        neg_reg  <= neg;
        word_reg <= word;
        mode_reg <= req.mode;
        lo_reg   <= req.bound_low;
    end

    // A negative span floors toward minus infinity: negate the ceiling.
    always_comb
    begin
        rounded = prod_reg + 65'h0_FFFF_FFFF;
        quot    = neg_reg ? rounded[64:32] : prod_reg[64:32];
        scaled  = neg_reg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
        unique case (mode_reg)
            ilst_pkg::MODE_SCALED:    base = 35'sd0;
            ilst_pkg::MODE_RANGE_INT: base = 35'(lo_reg);
            ilst_pkg::MODE_RANGE_FIX: base = 35'(lo_reg);
            default:                  base = 35'sd0;
        endcase
        if (mode_reg == ilst_pkg::MODE_RAW)
        begin
            sum = $signed({3'b000, word_reg});
        end
        else
        begin
            sum = base + scaled;
        end
        if (sum > VAL_MAX)
        begin
            value = VAL_MAX[32:0];
        end
        else if (sum < VAL_MIN)
        begin
            value = VAL_MIN[32:0];
        end
        else
        begin
            value = sum[32:0];
        end
    end

endmodule
